// ----- hdl/tplc_pkg.sv -----
// Shared widths and defaults for the tetrahedron point-location classifier.
`default_nettype none

package tplc_pkg;

    localparam int FIELD_BITS       = 48;
    localparam int NUM_POINTS       = 5;
    localparam int IN_DATA_BITS     = NUM_POINTS * FIELD_BITS;
    localparam int CODE_BITS        = 4;
    localparam int OUT_DATA_BITS    = 8;
    localparam int COORD_BITS_DEF   = 16;

endpackage

`default_nettype wire

// ----- hdl/tetra_point_location_classifier.sv -----
// Pipelined point-in-tetrahedron classifier using exact integer Cramer determinants.
//
//  channel   dir  handshake          payload
//  s_*       in   s_tvalid/s_tready  s_tdata: vertex_a, vertex_b, vertex_c, vertex_d, query_point
//  m_*       out  m_tvalid/m_tready  m_tdata: location_code; m_tuser: degenerate
//
// One request per cycle unless m_tready back-pressure fills the pipeline.
// Depth is set by the two multiply levels (cross-product minors, then the dot products),
// each followed by its own add stage, plus the difference and classify stages.
// Every stage holds its own valid bit; a stage moves when it is empty or its successor moves.
// rst_n clears the valid bits only; data registers carry no reset.
`default_nettype none

module tetra_point_location_classifier
    import tplc_pkg::*;
#(
    parameter int COORD_BITS = COORD_BITS_DEF
)
(
    input  wire logic                     clk,
    input  wire logic                     rst_n,
    input  wire logic                     s_tvalid,
    output logic                          s_tready,
    // [47:0] vertex_a, [95:48] vertex_b, [143:96] vertex_c, [191:144] vertex_d,
    // [239:192] query_point
    input  wire logic [IN_DATA_BITS-1:0]  s_tdata,
    output logic                          m_tvalid,
    input  wire logic                     m_tready,
    // [3:0] location_code, [7:4] zero
    output logic [OUT_DATA_BITS-1:0]      m_tdata,
    // [0] degenerate
    output logic                          m_tuser
);

    localparam int NSTAGE = 6;
    localparam int XW     = 3 * COORD_BITS + FIELD_BITS;
    localparam int DW     = COORD_BITS + 1;
    localparam int PW     = 2 * DW;
    localparam int MW     = PW + 1;
    localparam int TW     = MW + DW;
    localparam int SW     = TW + 2;
    localparam int NW     = SW + 2;

    // cross-product pairs: (e2,e3), (q,e3), (e2,q); rows 0..3 = e1, e2, e3, q
    localparam int U_SEL [3] = '{1, 3, 1};
    localparam int V_SEL [3] = '{2, 2, 3};
    // dot products: D = e1.x0, N1 = q.x0, N2 = e1.x1, N3 = e1.x2; kept rows 0 = e1, 1 = q
    localparam int ROW_SEL [4] = '{0, 1, 0, 0};
    localparam int MP_SEL  [4] = '{0, 0, 1, 2};

    logic [NSTAGE-1:0] vld_reg;
    logic [NSTAGE-1:0] adv;

    logic signed [COORD_BITS-1:0] lane [NUM_POINTS][3];
    logic signed [DW-1:0]         ev_next [4][3];
    logic signed [DW-1:0]         ev_reg  [4][3];
    logic signed [PW-1:0]         prod_next [3][6];
    logic signed [PW-1:0]         prod_reg  [3][6];
    logic signed [DW-1:0]         keep2_reg [2][3];
    logic signed [MW-1:0]         minor_next [3][3];
    logic signed [MW-1:0]         minor_reg  [3][3];
    logic signed [DW-1:0]         keep3_reg [2][3];
    logic signed [TW-1:0]         term_next [4][3];
    logic signed [TW-1:0]         term_reg  [4][3];
    logic signed [SW-1:0]         sum_next [4];
    logic signed [SW-1:0]         sum_reg  [4];
    logic signed [NW-1:0]         num [4];
    logic [CODE_BITS-1:0]         pos;
    logic [CODE_BITS-1:0]         neg;
    logic                         den_zero;
    logic [CODE_BITS-1:0]         code_next;
    logic [CODE_BITS-1:0]         code_reg;
    logic                         degen_reg;

    always_comb
    begin
        adv[NSTAGE-1] = !vld_reg[NSTAGE-1] || m_tready;
        for (int k = NSTAGE - 2; k >= 0; k--)
        begin
            adv[k] = !vld_reg[k] || adv[k+1];
        end
    end

    assign s_tready = adv[0];

    generate
        for (genvar f = 0; f < NUM_POINTS; f++)
        begin : g_lane
            logic [XW-1:0] wide;
            assign wide = XW'(s_tdata[f*FIELD_BITS +: FIELD_BITS]);
            for (genvar k = 0; k < 3; k++)
            begin : g_axis
                assign lane[f][k] = wide[k*COORD_BITS +: COORD_BITS];
            end
        end
    endgenerate

    always_comb
    begin
        for (int r = 0; r < 4; r++)
        begin
            for (int k = 0; k < 3; k++)
            begin
                ev_next[r][k] = DW'(lane[r+1][k]) - DW'(lane[0][k]);
            end
        end
        for (int j = 0; j < 3; j++)
        begin
            prod_next[j][0] = PW'(ev_reg[U_SEL[j]][1] * ev_reg[V_SEL[j]][2]);
            prod_next[j][1] = PW'(ev_reg[U_SEL[j]][2] * ev_reg[V_SEL[j]][1]);
            prod_next[j][2] = PW'(ev_reg[U_SEL[j]][0] * ev_reg[V_SEL[j]][2]);
            prod_next[j][3] = PW'(ev_reg[U_SEL[j]][2] * ev_reg[V_SEL[j]][0]);
            prod_next[j][4] = PW'(ev_reg[U_SEL[j]][0] * ev_reg[V_SEL[j]][1]);
            prod_next[j][5] = PW'(ev_reg[U_SEL[j]][1] * ev_reg[V_SEL[j]][0]);
            for (int m = 0; m < 3; m++)
            begin
                minor_next[j][m] = MW'(prod_reg[j][2*m]) - MW'(prod_reg[j][2*m+1]);
            end
        end
        for (int t = 0; t < 4; t++)
        begin
            for (int m = 0; m < 3; m++)
            begin
                term_next[t][m] = TW'(keep3_reg[ROW_SEL[t]][m] * minor_reg[MP_SEL[t]][m]);
            end
            sum_next[t] = SW'(term_reg[t][0]) - SW'(term_reg[t][1]) + SW'(term_reg[t][2]);
        end
    end

    always_comb
    begin
        num[0]   = NW'(sum_reg[0]) - NW'(sum_reg[1]) - NW'(sum_reg[2]) - NW'(sum_reg[3]);
        for (int t = 1; t < 4; t++)
        begin
            num[t] = NW'(sum_reg[t]);
        end
        den_zero = (sum_reg[0] == '0);
        for (int t = 0; t < 4; t++)
        begin
            pos[t] = (num[t] != '0) && (num[t][NW-1] == sum_reg[0][SW-1]);
            neg[t] = (num[t] != '0) && (num[t][NW-1] != sum_reg[0][SW-1]);
        end
        code_next = (den_zero || (|neg)) ? '0 : pos;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else
        begin
            if (adv[0])
            begin
                vld_reg[0] <= s_tvalid;
            end
            for (int k = 1; k < NSTAGE; k++)
            begin
                if (adv[k])
                begin
                    vld_reg[k] <= vld_reg[k-1];
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv[0] && s_tvalid)
        begin
            ev_reg <= ev_next;
        end
        if (adv[1] && vld_reg[0])
        begin
            prod_reg <= prod_next;
            keep2_reg[0] <= ev_reg[0];
            keep2_reg[1] <= ev_reg[3];
        end
        if (adv[2] && vld_reg[1])
        begin
            minor_reg <= minor_next;
            keep3_reg <= keep2_reg;
        end
        if (adv[3] && vld_reg[2])
        begin
            term_reg <= term_next;
        end
        if (adv[4] && vld_reg[3])
        begin
            sum_reg <= sum_next;
        end
        if (adv[5] && vld_reg[4])
        begin
            code_reg  <= code_next;
            degen_reg <= den_zero;
        end
    end

    assign m_tvalid = vld_reg[NSTAGE-1];
    assign m_tdata  = OUT_DATA_BITS'(code_reg);
    assign m_tuser  = degen_reg;

endmodule

`default_nettype wire

// ----- hdl/tplc_check.sv -----
// Port-level checks for the tetrahedron point-location classifier, bound to the top level.
`default_nettype none

module tplc_check
    import tplc_pkg::*;
(
    input wire logic                     clk,
    input wire logic                     rst_n,
    input wire logic                     s_tready,
    input wire logic                     m_tvalid,
    input wire logic                     m_tready,
    input wire logic [OUT_DATA_BITS-1:0] m_tdata,
    input wire logic                     m_tuser
);

    a_degen_code_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tuser |-> m_tdata[CODE_BITS-1:0] == '0)
        else $error("degenerate result with nonzero location code");

    a_pad_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> m_tdata[OUT_DATA_BITS-1:CODE_BITS] == '0)
        else $error("padding bits of result set");

    a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
        !m_tvalid |-> s_tready)
        else $error("input stalled while output stage empty");

    a_hold_stalled: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("stalled result changed or dropped");

endmodule

bind tetra_point_location_classifier tplc_check u_tplc_check
(
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);

`default_nettype wire
